@@ rtl/core/pmf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmf_pkg
// Types and constants shared by the power mean filter.
// ----------------------------------------------------------------------------
package pmf_pkg;

    localparam int WIDE_W = 128;

    localparam logic [1:0] BORDER_CROP   = 2'd0;
    localparam logic [1:0] BORDER_EXTEND = 2'd1;
    localparam logic [1:0] BORDER_WRAP   = 2'd2;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [2:0] REG_BORDER  = 3'd0;
    localparam logic [2:0] REG_KERNEL  = 3'd1;
    localparam logic [2:0] REG_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_WIDTH   = 3'd3;
    localparam logic [2:0] REG_DIVISOR = 3'd4;

    typedef struct packed {
        logic       opcode;
        logic [8:0] row;
        logic [8:0] col;
        logic [7:0] pixel_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] filtered_value;
        logic       out_of_range;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_TAP_ADDR,
        ST_TAP_READ,
        ST_TAP_POW,
        ST_TAP_ADD,
        ST_ROOT_INIT,
        ST_ROOT_POW,
        ST_ROOT_DIV,
        ST_ROOT_CMP,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic write_pix;
        logic tap_addr;
        logic pow_start;
        logic pow_step;
        logic tap_add;
        logic root_init;
        logic root_pow_start;
        logic root_mul_div;
        logic root_cmp;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_write;
        logic oor;
        logic tap_last;
        logic pow_done;
        logic root_last;
    } t_status;

    function automatic logic [2:0] kernel_weight(input logic sel, input logic [3:0] tap);
        logic [2:0] w;
        begin
            w = 3'd1;
            if (sel) begin
                case (tap)
                    4'd4:                      w = 3'd4;
                    4'd1, 4'd3, 4'd5, 4'd7:   w = 3'd2;
                    default:                   w = 3'd1;
                endcase
            end
            return w;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/power_mean_filter_3x3.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// power_mean_filter_3x3
// Compute time is set by the serial 128 x 11 multiplier shared by taps
// and root search. One word at a time.
// Reset: synchronous, config and FSM registers to their defaults.
// Datapath registers and the frame store are left undefined.
// ----------------------------------------------------------------------------
module power_mean_filter_3x3 #(
    parameter int MAX_ROWS = 512,
    parameter int MAX_COLS = 512,
    parameter int POWER    = 10
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  pmf_pkg::t_in_word   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output pmf_pkg::t_out_word  o_out_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [2:0]           i_cfg_index,
    input  wire [9:0]           i_cfg_data
);

    logic [1:0] r_border;
    logic       r_kernel;
    logic [9:0] r_height, r_width, r_divisor;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border  <= pmf_pkg::BORDER_EXTEND;
            r_kernel  <= 1'b0;
            r_height  <= 10'd512;
            r_width   <= 10'd512;
            r_divisor <= 10'd9;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pmf_pkg::REG_BORDER:  r_border  <= (i_cfg_data[1:0] == 2'd3)
                                                   ? pmf_pkg::BORDER_EXTEND : i_cfg_data[1:0];
                pmf_pkg::REG_KERNEL:  r_kernel  <= i_cfg_data[0];
                pmf_pkg::REG_HEIGHT:  r_height  <= i_cfg_data;
                pmf_pkg::REG_WIDTH:   r_width   <= i_cfg_data;
                pmf_pkg::REG_DIVISOR: r_divisor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pmf_pkg::t_cmd    cmd;
    pmf_pkg::t_status status;

    pmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pmf_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .POWER    (POWER)
    ) u_dp (
        .i_clk           (i_clk),
        .i_in_word       (i_in_data),
        .i_cmd           (cmd),
        .i_border_mode   (r_border),
        .i_kernel_select (r_kernel),
        .i_image_height  (r_height),
        .i_image_width   (r_width),
        .i_divisor       (r_divisor),
        .o_status        (status),
        .o_out_word      (o_out_data)
    );

endmodule
`default_nettype wire

@@ rtl/core/pmf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmf_ctrl
// Sequencer for tap reads, power accumulation and the bitwise root search.
// ----------------------------------------------------------------------------
module pmf_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  pmf_pkg::t_status  i_status,
    output pmf_pkg::t_cmd     o_cmd
);

    pmf_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            pmf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pmf_pkg::ST_WRITE;
                end
            end
            pmf_pkg::ST_WRITE: begin
                if (i_status.is_write) begin
                    o_cmd.write_pix = 1'b1;
                    n_state         = pmf_pkg::ST_IDLE;
                end else if (i_status.oor) begin
                    n_state = pmf_pkg::ST_OUT;
                end else begin
                    n_state = pmf_pkg::ST_TAP_ADDR;
                end
            end
            pmf_pkg::ST_TAP_ADDR: begin
                o_cmd.tap_addr = 1'b1;
                n_state        = pmf_pkg::ST_TAP_READ;
            end
            pmf_pkg::ST_TAP_READ: begin
                o_cmd.pow_start = 1'b1;
                n_state         = pmf_pkg::ST_TAP_POW;
            end
            pmf_pkg::ST_TAP_POW: begin
                if (i_status.pow_done) begin
                    n_state = pmf_pkg::ST_TAP_ADD;
                end else begin
                    o_cmd.pow_step = 1'b1;
                end
            end
            pmf_pkg::ST_TAP_ADD: begin
                o_cmd.tap_add  = 1'b1;
                n_state = i_status.tap_last ? pmf_pkg::ST_ROOT_INIT : pmf_pkg::ST_TAP_ADDR;
            end
            pmf_pkg::ST_ROOT_INIT: begin
                o_cmd.root_init = 1'b1;
                n_state         = pmf_pkg::ST_ROOT_POW;
                o_cmd.root_pow_start = 1'b1;
            end
            pmf_pkg::ST_ROOT_POW: begin
                if (i_status.pow_done) begin
                    n_state = pmf_pkg::ST_ROOT_DIV;
                end else begin
                    o_cmd.pow_step = 1'b1;
                end
            end
            pmf_pkg::ST_ROOT_DIV: begin
                o_cmd.root_mul_div = 1'b1;
                n_state            = pmf_pkg::ST_ROOT_CMP;
            end
            pmf_pkg::ST_ROOT_CMP: begin
                o_cmd.root_cmp = 1'b1;
                if (i_status.root_last) begin
                    n_state = pmf_pkg::ST_OUT;
                end else begin
                    o_cmd.root_pow_start = 1'b1;
                    n_state              = pmf_pkg::ST_ROOT_POW;
                end
            end
            pmf_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = pmf_pkg::ST_IDLE;
                end
            end
            default: n_state = pmf_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/pmf_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmf_dp
// Frame store, tap addressing, serial power unit, accumulator and root search.
// ----------------------------------------------------------------------------
module pmf_dp #(
    parameter int MAX_ROWS = 512,
    parameter int MAX_COLS = 512,
    parameter int POWER    = 10
) (
    input  wire                 i_clk,
    input  pmf_pkg::t_in_word   i_in_word,
    input  pmf_pkg::t_cmd       i_cmd,
    input  wire [1:0]           i_border_mode,
    input  wire                 i_kernel_select,
    input  wire [9:0]           i_image_height,
    input  wire [9:0]           i_image_width,
    input  wire [9:0]           i_divisor,
    output pmf_pkg::t_status    o_status,
    output pmf_pkg::t_out_word  o_out_word
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;
    localparam int PW = $clog2(POWER + 1);
    localparam int W  = pmf_pkg::WIDE_W;

    logic [7:0] r_mem [0:(2**AW)-1];

    pmf_pkg::t_in_word r_word;
    logic [10:0]  r_h, r_w;
    logic [3:0]   r_tap;
    logic         r_skip;
    logic [7:0]   r_pix;
    logic [10:0]  r_base;
    logic [PW-1:0] r_pcnt;
    logic [W-1:0] r_pow;
    logic [W-1:0] r_sum;
    logic [W-1:0] r_prod;
    logic [7:0]   r_res;
    logic [7:0]   r_bit;
    pmf_pkg::t_out_word r_out;

    logic [10:0] h_eff, w_eff;
    always_comb begin
        h_eff = (i_image_height > 10'(MAX_ROWS > 1023 ? 1023 : MAX_ROWS))
              ? 11'(MAX_ROWS) : {1'b0, i_image_height};
        w_eff = (i_image_width > 10'(MAX_COLS > 1023 ? 1023 : MAX_COLS))
              ? 11'(MAX_COLS) : {1'b0, i_image_width};
    end

    // tap coordinate resolution
    logic signed [12:0] tr, tc;
    logic [10:0] rr, cc;
    logic        skip;
    logic [1:0]  ti, tj;
    always_comb begin
        case (r_tap)
            4'd0: begin ti = 2'd0; tj = 2'd0; end
            4'd1: begin ti = 2'd0; tj = 2'd1; end
            4'd2: begin ti = 2'd0; tj = 2'd2; end
            4'd3: begin ti = 2'd1; tj = 2'd0; end
            4'd4: begin ti = 2'd1; tj = 2'd1; end
            4'd5: begin ti = 2'd1; tj = 2'd2; end
            4'd6: begin ti = 2'd2; tj = 2'd0; end
            4'd7: begin ti = 2'd2; tj = 2'd1; end
            default: begin ti = 2'd2; tj = 2'd2; end
        endcase
        tr = $signed({4'd0, r_word.row}) + $signed({11'd0, ti}) - 13'sd1;
        tc = $signed({4'd0, r_word.col}) + $signed({11'd0, tj}) - 13'sd1;
        skip = 1'b0;
        rr = tr[10:0];
        cc = tc[10:0];
        if (i_border_mode == pmf_pkg::BORDER_CROP) begin
            if (tr < 0 || tr >= $signed({2'd0, r_h}) || tc < 0 || tc >= $signed({2'd0, r_w}))
                skip = 1'b1;
        end else if (i_border_mode == pmf_pkg::BORDER_WRAP) begin
            if (tr < 0) rr = 11'(tr + $signed({2'd0, r_h}));
            else if (tr >= $signed({2'd0, r_h})) rr = 11'(tr - $signed({2'd0, r_h}));
            if (tc < 0) cc = 11'(tc + $signed({2'd0, r_w}));
            else if (tc >= $signed({2'd0, r_w})) cc = 11'(tc - $signed({2'd0, r_w}));
        end else begin
            if (tr < 0) rr = 11'd0;
            else if (tr >= $signed({2'd0, r_h})) rr = r_h - 11'd1;
            if (tc < 0) cc = 11'd0;
            else if (tc >= $signed({2'd0, r_w})) cc = r_w - 11'd1;
        end
    end

    logic [AW-1:0] wr_addr;
    logic          wr_ok;
    assign wr_addr = {RW'(r_word.row), CW'(r_word.col)};
    assign wr_ok   = ({2'd0, r_word.row} < 11'(MAX_ROWS)) && ({2'd0, r_word.col} < 11'(MAX_COLS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_pix && wr_ok) begin
            r_mem[wr_addr] <= r_word.pixel_value;
        end
        if (i_cmd.tap_addr) begin
            r_pix <= r_mem[{rr[RW-1:0], cc[CW-1:0]}];
        end
    end

    logic [W-1:0] mul_out;
    logic [10:0]  mul_m;
    logic [9:0]   div_eff;
    logic [7:0]   res_upd;
    assign div_eff = (i_divisor == 10'd0) ? 10'd1 : i_divisor;
    assign mul_m   = i_cmd.root_mul_div ? {1'b0, div_eff} : r_base;
    assign mul_out = r_pow * W'(mul_m);
    assign res_upd = (r_prod <= r_sum) ? r_base[7:0] : r_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_in_word;
            r_h    <= h_eff;
            r_w    <= w_eff;
            r_tap  <= 4'd0;
            r_sum  <= '0;
        end
        if (i_cmd.tap_addr) begin
            r_skip <= skip;
        end
        if (i_cmd.pow_start) begin
            r_base <= 11'(r_pix) * 11'(pmf_pkg::kernel_weight(i_kernel_select, r_tap));
            r_pow  <= W'(1);
            r_pcnt <= '0;
        end
        if (i_cmd.root_pow_start) begin
            r_base <= {3'd0, i_cmd.root_init ? 8'h80 : (res_upd | (r_bit >> 1))};
            r_pow  <= W'(1);
            r_pcnt <= '0;
        end
        if (i_cmd.pow_step) begin
            r_pow  <= mul_out;
            r_pcnt <= r_pcnt + PW'(1);
        end
        if (i_cmd.tap_add) begin
            if (!r_skip) r_sum <= r_sum + r_pow;
            r_tap <= r_tap + 4'd1;
        end
        if (i_cmd.root_init) begin
            r_res <= 8'd0;
            r_bit <= 8'h80;
        end
        if (i_cmd.root_mul_div) begin
            r_prod <= mul_out;
        end
        if (i_cmd.root_cmp) begin
            r_res <= res_upd;
            r_bit <= r_bit >> 1;
        end
        if (i_cmd.out_load) begin
            r_out.filtered_value <= o_status.oor ? 8'd0 : r_res;
            r_out.out_of_range   <= o_status.oor;
        end
    end

    assign o_status.is_write  = (r_word.opcode == pmf_pkg::OP_WRITE);
    assign o_status.oor       = ({2'd0, r_word.row} >= r_h) || ({2'd0, r_word.col} >= r_w);
    assign o_status.tap_last  = (r_tap == 4'd8);
    assign o_status.pow_done  = (r_pcnt == PW'(POWER));
    assign o_status.root_last = (r_bit == 8'd1);
    assign o_out_word = r_out;

endmodule
`default_nettype wire

@@ tb/sv/pmf_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmf_result_checker
// Watches the input, configuration and result channels of the power mean
// filter, keeps its own frame store and register copy, computes the 3x3
// weighted power mean of every accepted compute word and compares each
// accepted result word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pmf_result_checker
    import pmf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_ready,
    input  t_in_word   i_in_data,
    input  wire        i_out_valid,
    input  wire        i_out_ready,
    input  t_out_word  i_out_data,
    input  wire        i_cfg_valid,
    input  wire        i_cfg_ready,
    input  wire [2:0]  i_cfg_index,
    input  wire [9:0]  i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    logic [7:0]  pix_mem [0:262143];
    logic [1:0]  border_mode;
    logic        kernel_sel;
    logic [9:0]  img_height;
    logic [9:0]  img_width;
    logic [9:0]  div_reg;
    t_out_word   filtered_q[$];
    int          errs;

    function automatic logic [127:0] pow10(input logic [127:0] x);
        logic [127:0] acc;
        acc = 128'd1;
        for (int k = 0; k < 10; k++) acc = acc * x;
        return acc;
    endfunction

    function automatic t_out_word power_mean(input int row, input int col);
        t_out_word    res;
        int           hc;
        int           wc;
        int           r;
        int           c;
        logic [127:0] sum;
        logic [127:0] wt;
        logic [127:0] d;
        logic [7:0]   root;
        logic [7:0]   cand;
        hc = (img_height > 512) ? 512 : img_height;
        wc = (img_width > 512) ? 512 : img_width;
        res = '0;
        if (row >= hc || col >= wc) begin
            res.out_of_range = 1'b1;
            return res;
        end
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r = row + i - 1;
                c = col + j - 1;
                if (border_mode == BORDER_CROP) begin
                    if (r < 0 || r >= hc || c < 0 || c >= wc) continue;
                end else if (border_mode == BORDER_WRAP) begin
                    if (r < 0) r += hc; else if (r >= hc) r -= hc;
                    if (c < 0) c += wc; else if (c >= wc) c -= wc;
                end else begin
                    if (r < 0) r = 0; else if (r >= hc) r = hc - 1;
                    if (c < 0) c = 0; else if (c >= wc) c = wc - 1;
                end
                wt = kernel_sel ? ((i == 1) ? 2 : 1) * ((j == 1) ? 2 : 1) : 1;
                sum = sum + pow10(wt * pix_mem[r * 512 + c]);
            end
        end
        d = (div_reg == 0) ? 128'd1 : div_reg;
        root = '0;
        for (int b = 7; b >= 0; b--) begin
            cand = root | (8'd1 << b);
            if (pow10(cand) * d <= sum) root = cand;
        end
        res.filtered_value = root;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            border_mode <= BORDER_EXTEND;
            kernel_sel  <= 1'b0;
            img_height  <= 10'd512;
            img_width   <= 10'd512;
            div_reg     <= 10'd9;
            filtered_q.delete();
            errs = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_BORDER:  border_mode <= i_cfg_data[1:0];
                    REG_KERNEL:  kernel_sel  <= i_cfg_data[0];
                    REG_HEIGHT:  img_height  <= i_cfg_data;
                    REG_WIDTH:   img_width   <= i_cfg_data;
                    REG_DIVISOR: div_reg     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    $error("unexpected result word %p", i_out_data);
                    errs++;
                end else begin
                    want = filtered_q.pop_front();
                    if (want.filtered_value !== i_out_data.filtered_value) begin
                        $error("filtered_value: expected %0d, actual %0d",
                               want.filtered_value, i_out_data.filtered_value);
                        errs++;
                    end
                    if (want.out_of_range !== i_out_data.out_of_range) begin
                        $error("out_of_range: expected %0d, actual %0d",
                               want.out_of_range, i_out_data.out_of_range);
                        errs++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.opcode == OP_WRITE)
                    pix_mem[i_in_data.row * 512 + i_in_data.col] = i_in_data.pixel_value;
                else
                    filtered_q.push_back(power_mean(i_in_data.row, i_in_data.col));
            end
        end
        o_fail_count <= errs;
        o_pending    <= filtered_q.size();
    end

endmodule

@@ tb/sv/power_mean_filter_3x3_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_mean_filter_3x3_test
// Loads pixels and queries filtered values across border modes, kernels,
// image sizes and divisors, with bursty input, random output stalls and one
// long output hold; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module power_mean_filter_3x3_test;
    import pmf_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_word   in_data;
    logic       out_valid;
    logic       out_ready;
    t_out_word  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [9:0] cfg_data;
    int         fail_count;
    int         pending;
    logic       hold_req;
    bit         written [0:262143];
    int         burst_left;
    int         cur_h;
    int         cur_w;

    power_mean_filter_3x3 DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    pmf_result_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: randomly chosen stall patterns, one long hold on request
    initial begin
        int  mode;
        bit  hold_done;
        out_ready = 1'b0;
        hold_done = 0;
        mode = 0;
        forever begin
            for (int k = 0; k < 200; k++) begin
                @(posedge clk);
                if (hold_req && !hold_done) begin
                    out_ready <= 1'b0;
                    repeat (700) @(posedge clk);
                    hold_done = 1;
                end
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    default: out_ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
            mode = $urandom_range(0, 2);
        end
    end

    initial begin
        #4000000;
        $display("power_mean_filter_3x3: mismatch");
        $finish;
    end

    task automatic send_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_data  <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (w.opcode == OP_WRITE) written[w.row * 512 + w.col] = 1;
    endtask

    task automatic write_pixel(input int row, input int col, input int pix);
        t_in_word w;
        w.opcode = OP_WRITE;
        w.row = 9'(row);
        w.col = 9'(col);
        w.pixel_value = 8'(pix);
        send_word(w);
    endtask

    function automatic int rand_pixel();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // load every pixel that any border mode may read around (row, col)
    task automatic compute_pixel(input int row, input int col);
        int       rows [5];
        int       cols [5];
        t_in_word w;
        rows = '{row - 1, row, row + 1, 0, cur_h - 1};
        cols = '{col - 1, col, col + 1, 0, cur_w - 1};
        if (row < cur_h && col < cur_w) begin
            foreach (rows[a]) begin
                foreach (cols[b]) begin
                    if (rows[a] >= 0 && rows[a] < cur_h && cols[b] >= 0 && cols[b] < cur_w
                        && !written[rows[a] * 512 + cols[b]])
                        write_pixel(rows[a], cols[b], rand_pixel());
                end
            end
        end
        w.opcode = OP_COMPUTE;
        w.row = 9'(row);
        w.col = 9'(col);
        w.pixel_value = 8'($urandom_range(0, 255));
        send_word(w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int value);
        cfg_index <= idx;
        cfg_data  <= 10'(value);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int border, input int kern, input int h, input int w,
                             input int div, input int n_items);
        int lim_r;
        int lim_c;
        drain();
        cfg_write(REG_BORDER, border);
        cfg_write(REG_KERNEL, kern);
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_DIVISOR, div);
        cur_h = (h > 512) ? 512 : h;
        cur_w = (w > 512) ? 512 : w;
        lim_r = (cur_h > 12) ? 12 : cur_h;
        lim_c = (cur_w > 12) ? 12 : cur_w;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 99) < 40) begin
                if ($urandom_range(0, 4) == 0)
                    compute_pixel($urandom_range(0, 511), $urandom_range(0, 511));
                else
                    compute_pixel($urandom_range(0, lim_r), $urandom_range(0, lim_c));
            end else if ($urandom_range(0, 9) == 0) begin
                write_pixel($urandom_range(0, 511), $urandom_range(0, 511), rand_pixel());
            end else begin
                write_pixel($urandom_range(0, lim_r), $urandom_range(0, lim_c), rand_pixel());
            end
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hold_req  = 1'b0;
        burst_left = 0;
        cur_h = 512;
        cur_w = 512;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: extend, box, full frame, divisor 9
        write_pixel(0, 0, 255);
        write_pixel(0, 1, 255);
        write_pixel(1, 0, 255);
        write_pixel(1, 1, 255);
        compute_pixel(0, 0);
        write_pixel(511, 511, 0);
        compute_pixel(511, 511);
        compute_pixel(0, 511);
        compute_pixel(511, 0);
        compute_pixel(255, 256);

        run_phase(BORDER_CROP, 1, 3, 3, 1, 80);
        run_phase(BORDER_WRAP, 0, 5, 7, 1023, 80);
        run_phase(BORDER_EXTEND, 1, 1, 1, 9, 40);
        run_phase(BORDER_WRAP, 1, 1, 512, 0, 60);
        run_phase(3, 0, 512, 1, 100, 60);
        run_phase(BORDER_CROP, 0, 1023, 1023, 1, 80);
        run_phase(BORDER_WRAP, 1, 0, 8, 5, 20);
        drain();
        hold_req <= 1'b1;
        run_phase(BORDER_EXTEND, 0, 512, 512, 9, 120);
        run_phase(BORDER_CROP, 1, 16, 16, 700, 80);
        drain();
        repeat (300) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("power_mean_filter_3x3: match");
        else
            $display("power_mean_filter_3x3: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/pmf_pkg.sv
rtl/core/pmf_ctrl.sv
rtl/core/pmf_dp.sv
rtl/core/power_mean_filter_3x3.sv
tb/sv/pmf_result_checker.sv
tb/sv/power_mean_filter_3x3_test.sv
